// ===== rtl/core/snegen_pkg.sv =====
// snegen_pkg: widths, stage schedule, constants and pipeline word type
// for the sine note envelope generator; depends on nothing
`default_nettype none

package snegen_pkg;

    // sine table and phase accumulator widths
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;
    localparam int QBITS           = SINE_TABLE_BITS - 2;

    // frequency table is unsigned q26, scaled to the phase width
    localparam int FREQ_FRAC  = 26;
    localparam int UP_SHIFT   = (PHASE_BITS > FREQ_FRAC) ? (PHASE_BITS - FREQ_FRAC) : 0;
    localparam int DOWN_SHIFT = (PHASE_BITS < FREQ_FRAC) ? (FREQ_FRAC - PHASE_BITS) : 0;
    localparam int FREQ_W     = 40;
    localparam int FNUM_W     = FREQ_W + UP_SHIFT;
    localparam int PROD_W     = PHASE_BITS + 24;

    typedef logic [FNUM_W-1:0]     fnum_t;
    typedef logic [PHASE_BITS-1:0] phase_t;
    typedef logic [PROD_W-1:0]     pprod_t;

    // quarter-wave polynomial coefficients, q15
    localparam logic [15:0] POLY_A = 16'd51472;
    localparam logic [15:0] POLY_B = 16'd21024;
    localparam logic [15:0] POLY_C = 16'd2320;

    // note length quotient saturates at 2^25 samples
    localparam int CNT_QBITS = 25;

    // configuration register indexes
    localparam logic [3:0] CFG_SAMPLE_RATE    = 4'd0;
    localparam logic [3:0] CFG_TEMPO_BPM      = 4'd1;
    localparam logic [3:0] CFG_TICKS_PER_BEAT = 4'd2;
    localparam logic [3:0] CFG_MASTER_GAIN    = 4'd3;

    // stage schedule, index of the pipeline register written by each step
    localparam int ST_MUL1    = 1;
    localparam int ST_MUL2    = 2;
    localparam int ST_PRE     = 3;
    localparam int CDIV_FIRST = 4;
    localparam int CDIV_LAST  = CDIV_FIRST + CNT_QBITS - 1;
    localparam int ST_CNT     = CDIV_LAST + 1;
    localparam int ST_DIFFK   = ST_CNT + 1;
    localparam int ST_SEL     = ST_DIFFK + 1;
    localparam int EDIV_FIRST = ST_SEL + 1;
    localparam int EDIV_LAST  = EDIV_FIRST + 16 - 1;
    localparam int SDIV_FIRST = ST_PRE;
    localparam int SDIV_LAST  = SDIV_FIRST + FNUM_W - 1;
    localparam int ST_PHASE   = ((EDIV_LAST > SDIV_LAST) ? EDIV_LAST : SDIV_LAST) + 1;
    localparam int ST_QUAD    = ST_PHASE + 1;
    localparam int ST_X2      = ST_QUAD + 1;
    localparam int ST_T1      = ST_X2 + 1;
    localparam int ST_T2      = ST_T1 + 1;
    localparam int ST_MAG     = ST_T2 + 1;
    localparam int ST_ME      = ST_MAG + 1;
    localparam int ST_PROD    = ST_ME + 1;
    localparam int ST_OUT     = ST_PROD + 1;
    localparam int NST        = ST_OUT + 1;

    typedef struct packed {
        logic [6:0]  tone;
        logic [19:0] ticks;
        logic [23:0] idx;
        logic        found;
        logic [15:0] pre;
        logic [15:0] ovl;
        logic [37:0] ts;
        logic [25:0] den;
        logic [6:0]  att;
        logic [6:0]  rel;
        logic [39:0] freq;
        logic [43:0] num;
        logic [24:0] att_sr;
        logic [24:0] rel_sr;
        fnum_t       fnum;
        logic        sat;
        logic [25:0] crem;
        logic [24:0] cq;
        logic [17:0] srem;
        phase_t      sq;
        logic [25:0] diff;
        logic [33:0] now;
        logic        past;
        logic        last;
        logic [35:0] diffk;
        logic        att_hit;
        logic        flat;
        logic [24:0] erem;
        logic [24:0] edv;
        logic [15:0] eq;
        logic [16:0] env;
        phase_t      phase;
        logic        neg;
        logic [15:0] x;
        logic [15:0] x2;
        logic [14:0] t1;
        logic [15:0] t2;
        logic [14:0] mag;
        logic [31:0] me;
        logic [47:0] prod;
        logic [15:0] sample;
    } pipe_t;

    // lowest octave of midi pitches, q26 hz
    function automatic logic [29:0] freq_q26(input logic [3:0] semi);
        logic [29:0] f;
        unique case (semi)
            4'd0:    f = 30'd548668578;
            4'd1:    f = 30'd581294109;
            4'd2:    f = 30'd615859655;
            4'd3:    f = 30'd652480576;
            4'd4:    f = 30'd691279090;
            4'd5:    f = 30'd732384684;
            4'd6:    f = 30'd775934544;
            4'd7:    f = 30'd822074013;
            4'd8:    f = 30'd870957077;
            4'd9:    f = 30'd922746880;
            4'd10:   f = 30'd977616269;
            4'd11:   f = 30'd1035748353;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sine_note_envelope_generator.sv =====
// sine_note_envelope_generator: pipelined sine note renderer with linear
// attack and release envelope; depends on snegen_pkg
//
// usage
//   s_ channel: one word per requested sample (tone, note length in ticks,
//   sample index, voicebank entry flag, preutterance and overlap).
//   m_ channel: one word per input word, signed q1.15 sample plus a flag on
//   the note's final sample. indexes past the note end give zero.
//   cfg channel: register writes (sample rate, tempo, ticks per beat, gain),
//   always ready; write only while no word is in flight.
// throughput: one word per clock while the skid word is empty. every stage is a register and all
//   divisions are unrolled restoring dividers, one quotient bit per stage.
// depth: the phase step divider (40 + PHASE_BITS - 26 stages) is the
//   longest path through the pipeline.
// stall: an output register plus a one word skid register follow the
//   pipeline; the pipeline and s_ready hold only once the skid word is full.
// reset: synchronous active low aresetn empties the pipeline and output and
//   loads 44100 samples/s, 120 bpm, 480 ticks per beat and unity gain.
`default_nettype none

module sine_note_envelope_generator (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [6:0]         s_midi_tone,
    input  wire logic [19:0]        s_length_ticks,
    input  wire logic [23:0]        s_sample_index,
    input  wire logic               s_entry_found,
    input  wire logic [15:0]        s_preutter_ms,
    input  wire logic [15:0]        s_overlap_ms,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_sample_value,
    output logic                    m_last_of_note,
    // configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_index,
    input  wire logic [17:0]        cfg_data
);

    // configuration registers
    logic [17:0] sample_rate_reg;
    logic [9:0]  tempo_bpm_reg;
    logic [15:0] ticks_per_beat_reg;
    logic [15:0] master_gain_reg;

    // zero rates and counts are taken as one
    logic [17:0] sr_eff;
    logic [9:0]  tb_eff;
    logic [15:0] tk_eff;

    // pipeline
    snegen_pkg::pipe_t p_reg [snegen_pkg::NST];
    snegen_pkg::pipe_t stg0_next;
    logic [snegen_pkg::NST-1:0] vld_reg;
    logic adv;
    logic pipe_exit;

    // output register and skid word
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [15:0] m_sample_reg;
    logic        m_last_reg;
    logic        skid_vld_reg;
    logic        skid_vld_next;
    logic [15:0] skid_sample_reg;
    logic        skid_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg    <= 18'd44100;
            tempo_bpm_reg      <= 10'd120;
            ticks_per_beat_reg <= 16'd480;
            master_gain_reg    <= 16'd16384;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                snegen_pkg::CFG_SAMPLE_RATE:    sample_rate_reg    <= cfg_data;
                snegen_pkg::CFG_TEMPO_BPM:      tempo_bpm_reg      <= cfg_data[9:0];
                snegen_pkg::CFG_TICKS_PER_BEAT: ticks_per_beat_reg <= cfg_data[15:0];
                snegen_pkg::CFG_MASTER_GAIN:    master_gain_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign sr_eff = (sample_rate_reg == '0) ? 18'd1 : sample_rate_reg;
    assign tb_eff = (tempo_bpm_reg == '0) ? 10'd1 : tempo_bpm_reg;
    assign tk_eff = (ticks_per_beat_reg == '0) ? 16'd1 : ticks_per_beat_reg;

    // the whole pipeline moves together until the skid word fills
    assign adv       = !skid_vld_reg;
    assign s_ready   = adv;
    assign pipe_exit = adv && vld_reg[snegen_pkg::NST-1];

    always_comb begin
        stg0_next       = '0;
        stg0_next.tone  = s_midi_tone;
        stg0_next.ticks = s_length_ticks;
        stg0_next.idx   = s_sample_index;
        stg0_next.found = s_entry_found;
        stg0_next.pre   = s_preutter_ms;
        stg0_next.ovl   = s_overlap_ms;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[snegen_pkg::NST-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[0] <= stg0_next;
        end
    end

    // one generate step per pipeline register; the step's role follows from
    // its index in the stage schedule, several roles may share a step
    for (genvar gs = 1; gs < snegen_pkg::NST; gs++) begin : g_stage
        snegen_pkg::pipe_t stg_next;

        always_comb begin : c_stage
            snegen_pkg::pipe_t p;
            logic [3:0]  oct;
            logic [3:0]  semi;
            logic [26:0] c_try;
            logic [17:0] s_rem_in;
            logic [18:0] s_try;
            logic [25:0] e_try;
            logic [25:0] cnt;
            snegen_pkg::pprod_t ph_full;
            logic [snegen_pkg::SINE_TABLE_BITS-1:0] sidx;
            logic [15:0] x_raw;
            logic [31:0] x2_full;
            logic [27:0] cx;
            logic [30:0] tx;
            logic [31:0] xt;
            logic [16:0] xs;
            logic [17:0] rnd;
            logic [17:0] rneg;

            p        = p_reg[gs-1];
            oct      = '0;
            semi     = '0;
            c_try    = '0;
            s_rem_in = '0;
            s_try    = '0;
            e_try    = '0;
            cnt      = '0;
            ph_full  = '0;
            sidx     = '0;
            x_raw    = '0;
            x2_full  = '0;
            cx       = '0;
            tx       = '0;
            xt       = '0;
            xs       = '0;
            rnd      = '0;
            rneg     = '0;
            stg_next = p;

            if (gs == snegen_pkg::ST_MUL1) begin
                stg_next.ts  = 38'(p.ticks) * 38'(sr_eff);
                stg_next.den = 26'(tb_eff) * 26'(tk_eff);
                if (!p.found) begin
                    stg_next.att = 7'd10;
                    stg_next.rel = 7'd30;
                end else begin
                    stg_next.att = (p.pre < 16'd5) ? 7'd5 :
                                   (p.pre > 16'd80) ? 7'd80 : p.pre[6:0];
                    stg_next.rel = (p.ovl < 16'd5) ? 7'd5 :
                                   (p.ovl > 16'd80) ? 7'd80 : p.ovl[6:0];
                end
                // tone / 12 by reciprocal, exact for seven bit tones
                oct  = 4'((13'(p.tone) * 13'd43) >> 9);
                semi = 4'(p.tone - 7'(7'(oct) * 7'd12));
                stg_next.freq = 40'(snegen_pkg::freq_q26(semi)) << oct;
            end

            if (gs == snegen_pkg::ST_MUL2) begin
                // ticks * rate * 60
                stg_next.num    = (44'(p.ts) << 6) - (44'(p.ts) << 2);
                stg_next.att_sr = 25'(p.att) * 25'(sr_eff);
                stg_next.rel_sr = 25'(p.rel) * 25'(sr_eff);
                stg_next.fnum   = (snegen_pkg::fnum_t'(p.freq) << snegen_pkg::UP_SHIFT)
                                  >> snegen_pkg::DOWN_SHIFT;
            end

            if (gs == snegen_pkg::ST_PRE) begin
                // quotient of 2^25 or more never changes the outcome
                stg_next.sat  = ({7'd0, p.num} >= {p.den, 25'd0});
                stg_next.crem = 26'(p.num >> snegen_pkg::CNT_QBITS);
            end

            if (gs >= snegen_pkg::CDIV_FIRST && gs <= snegen_pkg::CDIV_LAST) begin
                // note length divider, one quotient bit per step
                c_try = {p.crem, p.num[snegen_pkg::CNT_QBITS-1]};
                if (c_try >= {1'b0, p.den}) begin
                    stg_next.crem = 26'(c_try - {1'b0, p.den});
                    stg_next.cq   = {p.cq[23:0], 1'b1};
                end else begin
                    stg_next.crem = 26'(c_try);
                    stg_next.cq   = {p.cq[23:0], 1'b0};
                end
                stg_next.num = p.num << 1;
            end

            if (gs >= snegen_pkg::SDIV_FIRST && gs <= snegen_pkg::SDIV_LAST) begin
                // phase step divider, keeps the low phase bits of the quotient
                s_rem_in = (gs == snegen_pkg::SDIV_FIRST) ? 18'd0 : p.srem;
                s_try    = {s_rem_in, p.fnum[snegen_pkg::FNUM_W-1]};
                if (s_try >= {1'b0, sr_eff}) begin
                    stg_next.srem = 18'(s_try - {1'b0, sr_eff});
                    stg_next.sq   = {p.sq[snegen_pkg::PHASE_BITS-2:0], 1'b1};
                end else begin
                    stg_next.srem = 18'(s_try);
                    stg_next.sq   = {p.sq[snegen_pkg::PHASE_BITS-2:0], 1'b0};
                end
                stg_next.fnum = p.fnum << 1;
            end

            if (gs == snegen_pkg::ST_CNT) begin
                if (p.sat) begin
                    cnt = 26'd33554432;
                end else if (p.cq == '0) begin
                    cnt = 26'd1;
                end else begin
                    cnt = {1'b0, p.cq};
                end
                stg_next.past = ({2'b0, p.idx} >= cnt);
                stg_next.last = ({2'b0, p.idx} < cnt) && (26'({2'b0, p.idx} + 26'd1) == cnt);
                stg_next.diff = cnt - {2'b0, p.idx};
                stg_next.now  = 34'(p.idx) * 34'd1000;
            end

            if (gs == snegen_pkg::ST_DIFFK) begin
                stg_next.diffk   = 36'(p.diff) * 36'd1000;
                stg_next.att_hit = (p.now < 34'(p.att_sr));
            end

            if (gs == snegen_pkg::ST_SEL) begin
                // ramp ratio is a / d with a < d on either ramp
                stg_next.flat = !p.att_hit && !(p.diffk < 36'(p.rel_sr));
                stg_next.erem = p.att_hit ? 25'(p.now) : 25'(p.diffk);
                stg_next.edv  = p.att_hit ? p.att_sr : p.rel_sr;
            end

            if (gs >= snegen_pkg::EDIV_FIRST && gs <= snegen_pkg::EDIV_LAST) begin
                e_try = {p.erem, 1'b0};
                if (e_try >= {1'b0, p.edv}) begin
                    stg_next.erem = 25'(e_try - {1'b0, p.edv});
                    stg_next.eq   = {p.eq[14:0], 1'b1};
                end else begin
                    stg_next.erem = 25'(e_try);
                    stg_next.eq   = {p.eq[14:0], 1'b0};
                end
            end

            if (gs == snegen_pkg::ST_PHASE) begin
                ph_full        = snegen_pkg::pprod_t'(p.sq) * snegen_pkg::pprod_t'(p.idx);
                stg_next.phase = ph_full[snegen_pkg::PHASE_BITS-1:0];
                stg_next.env   = p.flat ? 17'h10000 : {1'b0, p.eq};
            end

            if (gs == snegen_pkg::ST_QUAD) begin
                sidx  = p.phase[snegen_pkg::PHASE_BITS-1 -: snegen_pkg::SINE_TABLE_BITS];
                x_raw = 16'(sidx[snegen_pkg::QBITS-1:0]) << (15 - snegen_pkg::QBITS);
                // odd quadrants run the quarter wave backwards
                stg_next.x   = sidx[snegen_pkg::QBITS] ? 16'(17'h08000 - 17'(x_raw)) : x_raw;
                stg_next.neg = sidx[snegen_pkg::QBITS+1];
            end

            if (gs == snegen_pkg::ST_X2) begin
                x2_full     = 32'(p.x) * 32'(p.x);
                stg_next.x2 = 16'(x2_full >> 15);
            end

            if (gs == snegen_pkg::ST_T1) begin
                cx          = 28'(snegen_pkg::POLY_C) * 28'(p.x2);
                stg_next.t1 = 15'(17'(snegen_pkg::POLY_B) - 17'(cx >> 15));
            end

            if (gs == snegen_pkg::ST_T2) begin
                tx          = 31'(p.t1) * 31'(p.x2);
                stg_next.t2 = 16'(17'(snegen_pkg::POLY_A) - 17'(tx >> 15));
            end

            if (gs == snegen_pkg::ST_MAG) begin
                xt           = 32'(p.x) * 32'(p.t2);
                xs           = 17'(xt >> 15);
                stg_next.mag = (xs > 17'd32767) ? 15'h7FFF : 15'(xs);
            end

            if (gs == snegen_pkg::ST_ME) begin
                stg_next.me = 32'(p.mag) * 32'(p.env);
            end

            if (gs == snegen_pkg::ST_PROD) begin
                stg_next.prod = 48'(p.me) * 48'(master_gain_reg);
            end

            if (gs == snegen_pkg::ST_OUT) begin
                // round half away from zero on the magnitude, then saturate
                rnd  = 18'((p.prod + 48'h0000_2000_0000) >> 30);
                rneg = (rnd > 18'd32768) ? 18'd32768 : rnd;
                if (p.past) begin
                    stg_next.sample = '0;
                end else if (!p.neg) begin
                    stg_next.sample = (rnd > 18'd32767) ? 16'h7FFF : 16'(rnd);
                end else begin
                    stg_next.sample = 16'(18'h10000 - rneg);
                end
                stg_next.last = p.last && !p.past;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                p_reg[gs] <= stg_next;
            end
        end
    end

    // output register with skid word behind it
    always_comb begin
        m_valid_next  = m_valid_reg;
        skid_vld_next = skid_vld_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_valid_next  = 1'b1;
                skid_vld_next = 1'b0;
            end else begin
                m_valid_next = pipe_exit;
            end
        end else if (pipe_exit) begin
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_sample_reg <= skid_sample_reg;
                m_last_reg   <= skid_last_reg;
            end else begin
                m_sample_reg <= p_reg[snegen_pkg::NST-1].sample;
                m_last_reg   <= p_reg[snegen_pkg::NST-1].last;
            end
        end else if (pipe_exit) begin
            skid_sample_reg <= p_reg[snegen_pkg::NST-1].sample;
            skid_last_reg   <= p_reg[snegen_pkg::NST-1].last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_sample_reg;
    assign m_last_of_note = m_last_reg;

    // the skid word is only ever filled behind a held output word
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_valid_reg)
        else $error("skid word full while output register empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid word filled without an output stall");

    // a word leaving the pipeline is never dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[snegen_pkg::NST-1] && !skid_vld_reg) |=> m_valid_reg)
        else $error("word leaving the pipeline was lost");

endmodule

`default_nettype wire
